// File: rtl/upbt_pkg.sv
// ----------------------------------------------------------------------------
// upbt_pkg
// shared types and codes for the udp port bind table
// ----------------------------------------------------------------------------
package upbt_pkg;

  // request codes
  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_SETOPT = 2'd1,
    OP_BIND   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BAD_SOCK = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NO_PORT  = 3'd4,
    ST_IN_USE   = 3'd5,
    ST_SHARERS  = 3'd6
  } status_t;

  // configuration register index (paddr bit 2)
  localparam logic REG_CORE_COUNT = 1'b0;
  localparam logic REG_LOCAL_IP   = 1'b1;

  localparam int CORE_W = 5;
  localparam logic [CORE_W-1:0] CORE_MAX = 5'd16;
  localparam logic [CORE_W-1:0] CORE_COUNT_RESET = 5'd1;

endpackage

// File: rtl/upbt_rem.sv
// ----------------------------------------------------------------------------
// upbt_rem
// bit-serial remainder of a socket number by the core count
// ----------------------------------------------------------------------------
module upbt_rem #(
  parameter int DIV_W = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [DIV_W-1:0]             dividend,
  input  logic [upbt_pkg::CORE_W-1:0]  divisor,
  output logic                         done,
  output logic [3:0]                   rem
);
  import upbt_pkg::*;

  localparam int N_W = $clog2(DIV_W + 1);

  logic                busy;
  logic [N_W-1:0]      left;
  logic [DIV_W-1:0]    shreg;
  logic [CORE_W-1:0]   dv;
  logic [CORE_W-1:0]   trial;
  logic [CORE_W-1:0]   step;

  // one dividend bit per cycle, restoring form
  always_comb begin
    trial = {rem, shreg[DIV_W-1]};
    step  = (trial >= dv) ? trial - dv : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= busy && (left == N_W'(1));
      if (start) begin
        busy <= 1'b1;
        left <= N_W'(DIV_W);
      end else if (busy) begin
        left <= left - N_W'(1);
        if (left == N_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dv    <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      rem   <= step[3:0];
    end
  end

endmodule

// File: rtl/udp_port_bind_table_top.sv
// ----------------------------------------------------------------------------
// udp_port_bind_table_top
// socket table and port binding table with ephemeral port pick
// ----------------------------------------------------------------------------
// latency, states passed before S_RESP: none for a full table, a bad socket or
//   a create with no cores; S_SCHK for set option or a port out of range; S_SCHK,
//   S_PCHK for a bind to a given port; S_MOD (serial remainder) for a create;
//   S_SCHK, S_SCAN (one port count read per cycle), S_PCHK for an ephemeral bind
// throughput: one request at a time, taken once the previous result is registered
// reset: synchronous; a pass over all PORT_LIMIT+1 ports clears the port store, in_stall high
// ----------------------------------------------------------------------------
module udp_port_bind_table_top #(
  parameter int SOCKET_COUNT     = 256,
  parameter int PORT_LIMIT       = 4095,
  parameter int FIRST_EPHEMERAL  = 1024,
  parameter int SHARERS_PER_PORT = 4,
  parameter int SCAN_LIMIT       = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  sock_id,
  input  logic        option_is_reuseport,
  input  logic [15:0] requested_port,
  input  logic [31:0] bind_ip,
  input  logic [31:0] request_tag,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        success,
  output logic [7:0]  new_sock_id,
  output logic [3:0]  assigned_core,
  output logic [11:0] bound_port,
  output logic [31:0] tag_out,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import upbt_pkg::*;

  // widths follow from the table sizes
  localparam int SOCK_W  = $clog2(SOCKET_COUNT);
  localparam int CNT_W   = $clog2(SOCKET_COUNT + 1);
  localparam int PORT_W  = $clog2(PORT_LIMIT + 1);
  localparam int SHR_W   = $clog2(SHARERS_PER_PORT + 1);
  localparam int ROW_W   = SHARERS_PER_PORT * SOCK_W + SHR_W;
  localparam int SCN_W   = $clog2(SCAN_LIMIT + 1);
  // only sockets below 256 can be named by a request, so only those need
  // a written flag
  localparam int VLD_N   = (SOCKET_COUNT < 256) ? SOCKET_COUNT : 256;
  localparam int VLD_W   = $clog2(VLD_N);
  localparam bit WINDOW_EMPTY = FIRST_EPHEMERAL > PORT_LIMIT;
  // first ephemeral port as a port number; unused when the window is empty
  localparam logic [PORT_W-1:0] FIRST_PORT = PORT_W'(FIRST_EPHEMERAL);
  localparam logic [PORT_W-1:0] LAST_PORT  = PORT_W'(PORT_LIMIT);

  typedef struct packed {
    logic [31:0]       addr;
    logic              shares;
    logic [PORT_W-1:0] port;
  } srec_t;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_SCHK  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_PCHK  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state;

  // configuration registers
  logic [CORE_W-1:0] core_count;
  logic [31:0]       default_ip;
  logic [CORE_W-1:0] core_lim;

  // table state kept in flops
  logic [CNT_W-1:0]  sock_cnt;
  logic [PORT_W-1:0] cursor;
  logic [VLD_N-1:0]  sock_vld;
  logic [PORT_W-1:0] clr_addr;

  // request held for the whole operation
  op_t               req_op;
  logic [7:0]        req_sid;
  logic              req_reuse;
  logic [15:0]       req_port;
  logic [31:0]       req_ip;
  logic              req_known;
  logic              req_sh;
  logic [PORT_W-1:0] tgt_port;

  // pending result
  status_t           res_status;
  logic [7:0]        res_new_id;
  logic [3:0]        res_core;
  logic [PORT_W-1:0] res_port;
  logic [31:0]       res_tag;

  // ephemeral scan
  logic [PORT_W-1:0] scan_port;
  logic [PORT_W-1:0] scan_prev;
  logic              scan_prev_vld;
  logic [SCN_W-1:0]  scan_iss;
  logic              scan_issue;
  logic              scan_found;
  logic              scan_fail;

  // socket store: port, share flag and address per socket
  srec_t             sock_mem [SOCKET_COUNT];
  srec_t             sock_q;
  logic              sock_re;
  logic              sock_we;
  logic [SOCK_W-1:0] sock_waddr;
  srec_t             sock_wdata;

  // port store: sharer count and member list per port
  logic [ROW_W-1:0]  port_mem [PORT_LIMIT + 1];
  logic [ROW_W-1:0]  port_q;
  logic              port_re;
  logic [PORT_W-1:0] port_raddr;
  logic              port_we;
  logic [PORT_W-1:0] port_waddr;
  logic [ROW_W-1:0]  port_wdata;

  // decode
  logic              acc;
  logic              table_full;
  logic              sid_bad;
  logic [PORT_W-1:0] cur_port;
  logic              cur_sh;
  logic [15:0]       bind_port;
  logic              range_bad;
  logic              need_pick;
  logic [PORT_W-1:0] scan_start;
  logic [SHR_W-1:0]  pcnt;
  logic              in_use;
  logic              sharers_full;
  logic              bind_ok;
  logic              rem_start;
  logic              rem_done;
  logic [3:0]        rem;

  // ---------------------------------------------------------------------------
  // configuration port, always ready
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LOCAL_IP) ? default_ip
                                             : {{(32-CORE_W){1'b0}}, core_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      core_count <= CORE_COUNT_RESET;
      default_ip <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_CORE_COUNT) begin
        core_count <= pwdata[CORE_W-1:0];
      end else begin
        default_ip <= pwdata;
      end
    end
  end

  // counts above 16 behave as 16
  assign core_lim = (core_count > CORE_MAX) ? CORE_MAX : core_count;

  // ---------------------------------------------------------------------------
  // request decode
  // ---------------------------------------------------------------------------
  assign in_stall   = (state != S_IDLE);
  assign acc        = in_valid && !in_stall;
  assign table_full = 32'(sock_cnt) >= SOCKET_COUNT;
  assign sid_bad    = 32'(sock_id) >= SOCKET_COUNT;
  assign rem_start  = acc && (op == OP_CREATE) && !table_full && (core_lim != '0);

  // a socket entry never written reads as unbound and not sharing
  assign cur_port   = req_known ? sock_q.port : '0;
  assign cur_sh     = req_known && sock_q.shares;
  // an already bound socket keeps its port
  assign bind_port  = (cur_port != '0) ? 16'(cur_port) : req_port;
  assign range_bad  = 32'(bind_port) > PORT_LIMIT;
  assign need_pick  = (bind_port == '0);
  assign scan_start = (32'(cursor) < FIRST_EPHEMERAL || 32'(cursor) > PORT_LIMIT)
                      ? FIRST_PORT : cursor;

  // scan: one read issued per cycle, the count of the previous one checked
  assign scan_found = scan_prev_vld && (port_q[SHR_W-1:0] == '0);
  assign scan_fail  = scan_prev_vld && (port_q[SHR_W-1:0] != '0) &&
                      (scan_iss == SCN_W'(SCAN_LIMIT));
  assign scan_issue = (state == S_SCAN) && (scan_iss != SCN_W'(SCAN_LIMIT)) &&
                      !scan_found;

  // sharing rules on the target port
  assign pcnt         = port_q[SHR_W-1:0];
  assign in_use       = (pcnt != '0) && !req_sh;
  assign sharers_full = 32'(pcnt) >= SHARERS_PER_PORT;
  assign bind_ok      = !in_use && !sharers_full;

  // ---------------------------------------------------------------------------
  // memory port control
  // ---------------------------------------------------------------------------
  always_comb begin
    sock_re    = acc;
    sock_we    = 1'b0;
    sock_waddr = SOCK_W'(sock_cnt);
    sock_wdata = '0;
    port_re    = 1'b0;
    port_raddr = scan_port;
    port_we    = 1'b0;
    port_waddr = clr_addr;
    port_wdata = '0;
    case (state)
      S_CLEAR: begin
        port_we = 1'b1;
      end
      S_IDLE: begin
        // new socket: unbound, not sharing, default address
        if (acc && (op == OP_CREATE) && !table_full) begin
          sock_we         = 1'b1;
          sock_wdata.addr = default_ip;
        end
      end
      S_SCHK: begin
        if ((req_op == OP_SETOPT) && req_reuse) begin
          sock_we           = 1'b1;
          sock_waddr        = SOCK_W'(req_sid);
          sock_wdata.addr   = sock_q.addr;
          sock_wdata.shares = 1'b1;
          sock_wdata.port   = cur_port;
        end
        if ((req_op == OP_BIND) && !range_bad && !need_pick) begin
          port_re    = 1'b1;
          port_raddr = PORT_W'(bind_port);
        end
      end
      S_SCAN: begin
        port_re = scan_issue;
      end
      S_PCHK: begin
        if (bind_ok) begin
          sock_we           = 1'b1;
          sock_waddr        = SOCK_W'(req_sid);
          sock_wdata.addr   = req_ip;
          sock_wdata.shares = req_sh;
          sock_wdata.port   = tgt_port;
          port_we           = 1'b1;
          port_waddr        = tgt_port;
          port_wdata        = port_q;
          port_wdata[SHR_W-1:0] = pcnt + SHR_W'(1);
          for (int k = 0; k < SHARERS_PER_PORT; k++) begin
            if (SHR_W'(k) == pcnt) begin
              port_wdata[SHR_W + k*SOCK_W +: SOCK_W] = SOCK_W'(req_sid);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (sock_we) begin
      sock_mem[sock_waddr] <= sock_wdata;
    end
    if (sock_re) begin
      sock_q <= sock_mem[SOCK_W'(sock_id)];
    end
  end

  always_ff @(posedge clk) begin
    if (port_we) begin
      port_mem[port_waddr] <= port_wdata;
    end
    if (port_re) begin
      port_q <= port_mem[port_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // core pick for a new socket
  // ---------------------------------------------------------------------------
  upbt_rem #(
    .DIV_W (SOCK_W)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (SOCK_W'(sock_cnt)),
    .divisor  (core_lim),
    .done     (rem_done),
    .rem      (rem)
  );

  // ---------------------------------------------------------------------------
  // sequencer and control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      sock_cnt  <= '0;
      cursor    <= FIRST_PORT;
      sock_vld  <= '0;
      out_valid <= 1'b0;
      scan_prev_vld <= 1'b0;
      scan_iss  <= '0;
    end else begin
      // the result state sets out_valid itself
      if (out_valid && !out_stall && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      if (sock_we && (32'(sock_waddr) < VLD_N)) begin
        sock_vld[VLD_W'(sock_waddr)] <= 1'b1;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + PORT_W'(1);
          if (clr_addr == LAST_PORT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            case (op_t'(op))
              OP_CREATE: begin
                if (table_full) begin
                  state <= S_RESP;
                end else begin
                  sock_cnt <= sock_cnt + CNT_W'(1);
                  state    <= (core_lim != '0) ? S_MOD : S_RESP;
                end
              end
              OP_SETOPT, OP_BIND: begin
                state <= sid_bad ? S_RESP : S_SCHK;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_MOD: begin
          if (rem_done) begin
            state <= S_RESP;
          end
        end
        S_SCHK: begin
          if (req_op == OP_SETOPT || range_bad) begin
            state <= S_RESP;
          end else if (need_pick) begin
            state <= WINDOW_EMPTY ? S_RESP : S_SCAN;
          end else begin
            state <= S_PCHK;
          end
          scan_iss      <= '0;
          scan_prev_vld <= 1'b0;
        end
        S_SCAN: begin
          scan_prev_vld <= scan_issue;
          if (scan_issue) begin
            scan_iss <= scan_iss + SCN_W'(1);
          end
          if (scan_found) begin
            cursor <= (scan_prev == LAST_PORT) ? FIRST_PORT : scan_prev + PORT_W'(1);
            state  <= S_PCHK;
          end else if (scan_fail) begin
            state <= S_RESP;
          end
        end
        S_PCHK: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // request and result payload
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (acc) begin
          req_op     <= op_t'(op);
          req_sid    <= sock_id;
          req_reuse  <= option_is_reuseport;
          req_port   <= requested_port;
          req_ip     <= bind_ip;
          req_known  <= sock_vld[VLD_W'(sock_id)];
          res_tag    <= request_tag;
          res_core   <= '0;
          res_port   <= '0;
          if (op == OP_CREATE) begin
            if (table_full) begin
              res_status <= ST_FULL;
              res_new_id <= '0;
            end else begin
              res_status <= ST_OK;
              res_new_id <= 8'(sock_cnt);
            end
          end else begin
            res_status <= sid_bad ? ST_BAD_SOCK : ST_OK;
            res_new_id <= '0;
          end
        end
      end
      S_MOD: begin
        if (rem_done) begin
          res_core <= rem;
        end
      end
      S_SCHK: begin
        req_sh    <= cur_sh;
        tgt_port  <= PORT_W'(bind_port);
        scan_port <= scan_start;
        if (req_op == OP_BIND) begin
          if (range_bad) begin
            res_status <= ST_RANGE;
          end else if (need_pick && WINDOW_EMPTY) begin
            res_status <= ST_NO_PORT;
          end
        end
      end
      S_SCAN: begin
        if (scan_issue) begin
          scan_prev <= scan_port;
          scan_port <= (scan_port == LAST_PORT) ? FIRST_PORT : scan_port + PORT_W'(1);
        end
        if (scan_found) begin
          tgt_port <= scan_prev;
        end else if (scan_fail) begin
          res_status <= ST_NO_PORT;
        end
      end
      S_PCHK: begin
        if (in_use) begin
          res_status <= ST_IN_USE;
        end else if (sharers_full) begin
          res_status <= ST_SHARERS;
        end else begin
          res_port <= tgt_port;
        end
      end
      S_RESP: begin
        if (!out_valid || !out_stall) begin
          status        <= res_status;
          success       <= (res_status == ST_OK);
          new_sock_id   <= res_new_id;
          assigned_core <= res_core;
          bound_port    <= 12'(res_port);
          tag_out       <= res_tag;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // the socket counter never passes the table size
  a_sock_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    32'(sock_cnt) <= SOCKET_COUNT)
    else $error("socket count beyond table size");

  // the scan never issues more reads than its window allows
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    32'(scan_iss) <= SCAN_LIMIT)
    else $error("ephemeral scan overran its limit");

  // a member is only added to a port below the sharer limit
  a_port_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_PCHK && port_we) |-> 32'(pcnt) < SHARERS_PER_PORT)
    else $error("port member added past sharer limit");

  // the ephemeral cursor stays inside the window
  a_cursor_window: assert property (@(posedge clk) disable iff (rst)
    WINDOW_EMPTY || (32'(cursor) >= FIRST_EPHEMERAL && 32'(cursor) <= PORT_LIMIT))
    else $error("ephemeral cursor left the window");

  // a result only appears from the result state
  a_out_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_RESP)
    else $error("result shown outside the result state");

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the udp port bind table: socket creation, port
// sharing options, binds to given and ephemeral ports, checked beat by beat
// against an in-bench model of the socket and port tables
// ----------------------------------------------------------------------------
module tb;
  import upbt_pkg::*;

  // block sizes, kept equal to the defaults of the top level
  localparam int N_SOCK    = 256;
  localparam int PORT_MAX  = 4095;
  localparam int EPH_FIRST = 1024;
  localparam int MAX_SHARE = 4;
  localparam int SCAN_WIN  = 64;

  // cycles without any beat before the run is abandoned; covers the port
  // store clearing pass after reset and the longest scan with stalls
  localparam int WATCHDOG = 20000;
  // quiet cycles after the last result, longer than the slowest request
  localparam int SETTLE   = 100;

  // one request beat
  typedef struct packed {
    op_t         op;
    logic [7:0]  sid;
    logic        reuse;
    logic [15:0] rport;
    logic [31:0] ip;
    logic [31:0] tag;
  } req_t;

  // one result beat
  typedef struct packed {
    status_t     st;
    logic        ok;
    logic [7:0]  sock;
    logic [3:0]  core;
    logic [11:0] port;
    logic [31:0] tag;
  } resp_t;

  // directed stimulus row; typed rows carry their result written out by hand
  typedef struct packed {
    req_t  req;
    logic  typed;
    resp_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = '0;
  logic [7:0]  sock_id = '0;
  logic        option_is_reuseport = 1'b0;
  logic [15:0] requested_port = '0;
  logic [31:0] bind_ip = '0;
  logic [31:0] request_tag = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic        success;
  logic [7:0]  new_sock_id;
  logic [3:0]  assigned_core;
  logic [11:0] bound_port;
  logic [31:0] tag_out;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  udp_port_bind_table_top #(
    .SOCKET_COUNT     (N_SOCK),
    .PORT_LIMIT       (PORT_MAX),
    .FIRST_EPHEMERAL  (EPH_FIRST),
    .SHARERS_PER_PORT (MAX_SHARE),
    .SCAN_LIMIT       (SCAN_WIN)
  ) uut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .op                  (op),
    .sock_id             (sock_id),
    .option_is_reuseport (option_is_reuseport),
    .requested_port      (requested_port),
    .bind_ip             (bind_ip),
    .request_tag         (request_tag),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .status              (status),
    .success             (success),
    .new_sock_id         (new_sock_id),
    .assigned_core       (assigned_core),
    .bound_port          (bound_port),
    .tag_out             (tag_out),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // table model: socket and port state plus the configuration as last written
  // ---------------------------------------------------------------------------
  logic [11:0] sk_port [N_SOCK];
  logic        sk_share [N_SOCK];
  logic [31:0] sk_addr [N_SOCK];
  logic [2:0]  port_users [PORT_MAX+1];
  int          sock_total;
  int          eph_cursor;
  logic [4:0]  cfg_cores;
  logic [31:0] cfg_ip;

  // results still owed by the block, oldest first
  resp_t       pending_resp [$];
  int          bad_resp_count = 0;
  int          quiet_cycles = 0;
  logic        calm = 1'b0;          // no idling on either side while set
  resp_t       seen;
  resp_t       want_now;

  // ports that many requests aim at, so sharing limits and clashes show up
  logic [15:0] hot_ports [4] = '{16'd1, 16'd1500, 16'd2048, 16'd4095};

  // ephemeral pick: scan a bounded window from the wrapping cursor for a port
  // with no sharers, returns 0 when none is found
  function automatic int pick_port();
    int span, start, nr;
    if (EPH_FIRST > PORT_MAX) return 0;
    span  = PORT_MAX - EPH_FIRST + 1;
    start = eph_cursor;
    // a cursor outside the window restarts at its first port
    if (start < EPH_FIRST || start > PORT_MAX) start = EPH_FIRST;
    for (int i = 0; i < SCAN_WIN; i++) begin
      nr = EPH_FIRST + ((start - EPH_FIRST + i) % span);
      if (port_users[nr] == 0) begin
        eph_cursor = (nr + 1 > PORT_MAX) ? EPH_FIRST : nr + 1;
        return nr;
      end
    end
    // window exhausted, cursor keeps its value
    return 0;
  endfunction

  // result of one request, updating the model state as the block would
  function automatic resp_t table_response(input req_t r);
    resp_t res;
    int    cc, port, cnt;
    res     = '0;
    res.st  = ST_OK;
    res.tag = r.tag;
    if (r.op == OP_CREATE) begin
      if (sock_total >= N_SOCK) begin
        res.st = ST_FULL;
      end else begin
        // core counts above 16 behave as 16, zero gives core 0
        cc = (cfg_cores > 5'd16) ? 16 : int'(cfg_cores);
        res.sock = 8'(sock_total);
        res.core = (cc != 0) ? 4'(sock_total % cc) : 4'd0;
        sk_port[sock_total]  = '0;
        sk_share[sock_total] = 1'b0;
        sk_addr[sock_total]  = cfg_ip;
        sock_total++;
      end
    end else if (int'(r.sid) >= N_SOCK) begin
      res.st = ST_BAD_SOCK;
    end else if (r.op == OP_SETOPT) begin
      // options other than port sharing succeed and change nothing
      if (r.reuse) sk_share[r.sid] = 1'b1;
    end else begin
      // a bound socket keeps its own port whatever was asked
      port = (sk_port[r.sid] != 0) ? int'(sk_port[r.sid]) : int'(r.rport);
      if (port > PORT_MAX) begin
        res.st = ST_RANGE;
      end else begin
        if (port == 0) port = pick_port();
        if (port == 0) begin
          res.st = ST_NO_PORT;
        end else begin
          cnt = int'(port_users[port]);
          if (cnt != 0 && !sk_share[r.sid]) begin
            res.st = ST_IN_USE;
          end else if (cnt >= MAX_SHARE) begin
            res.st = ST_SHARERS;
          end else begin
            // a sharing socket that binds again is counted once more
            sk_addr[r.sid]   = r.ip;
            sk_port[r.sid]   = 12'(port);
            port_users[port] = 3'(cnt + 1);
            res.port         = 12'(port);
          end
        end
      end
    end
    res.ok = (res.st == ST_OK);
    return res;
  endfunction

  // random request, mostly aimed at sockets that exist
  function automatic req_t rand_req();
    req_t r;
    int   roll, pick;
    roll = $urandom_range(99);
    if (roll < 8)       r.op = OP_NONE;
    else if (roll < 20) r.op = OP_CREATE;
    else if (roll < 45) r.op = OP_SETOPT;
    else                r.op = OP_BIND;
    if (sock_total > 0 && $urandom_range(99) < 85)
      r.sid = 8'($urandom_range(sock_total - 1));
    else
      r.sid = 8'($urandom);
    r.reuse = ($urandom_range(99) < 60);
    pick = $urandom_range(99);
    if (pick < 30)      r.rport = '0;
    else if (pick < 55) r.rport = hot_ports[$urandom_range(3)];
    else if (pick < 80) r.rport = 16'($urandom_range(PORT_MAX, 1));
    else if (pick < 92) r.rport = 16'($urandom_range(65535, PORT_MAX + 1));
    else                r.rport = 16'($urandom);
    r.ip  = $urandom;
    r.tag = $urandom;
    return r;
  endfunction

  function automatic plan_row_t row(input op_t o, input logic [7:0] sid,
                                    input logic reuse, input logic [15:0] rport,
                                    input logic [31:0] ip, input logic [31:0] tag,
                                    input logic typed, input status_t st,
                                    input logic [7:0] sock, input logic [3:0] core,
                                    input logic [11:0] port);
    plan_row_t p;
    p.req       = '{op: o, sid: sid, reuse: reuse, rport: rport, ip: ip, tag: tag};
    p.typed     = typed;
    p.want      = '0;
    p.want.st   = st;
    p.want.ok   = (st == ST_OK);
    p.want.sock = sock;
    p.want.core = core;
    p.want.port = port;
    p.want.tag  = tag;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // request side: every task starts and ends at a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_req(input req_t r, input logic typed, input resp_t want);
    resp_t res;
    // random idle cycles ahead of the beat
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    op                  <= r.op;
    sock_id             <= r.sid;
    option_is_reuseport <= r.reuse;
    requested_port      <= r.rport;
    bind_ip             <= r.ip;
    request_tag         <= r.tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // beat taken at this edge; op 3 is dropped without a result
    if (r.op != OP_NONE) begin
      res = table_response(r);
      pending_resp.push_back(typed ? want : res);
    end
  endtask

  // hold off until every owed result has come, then wait some more
  task automatic quiesce(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic cfg_write(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CORE_COUNT) cfg_cores = val[4:0];
    else                       cfg_ip    = val;
    @(posedge clk);
  endtask

  task automatic run_random(input int n);
    req_t r;
    int   sent;
    sent = 0;
    while (sent < n) begin
      // now and then let the table drain completely
      if ($urandom_range(149) == 0) quiesce(0);
      r = rand_req();
      send_req(r, 1'b0, '0);
      if (r.op != OP_NONE) sent++;
    end
  endtask

  // occupy every port of the scan window from the cursor with explicit binds,
  // then ask for an ephemeral port from a fresh socket: no free port
  task automatic block_window();
    req_t r;
    int   span, start, p, id;
    if (sock_total + SCAN_WIN + 1 > N_SOCK) return;
    span  = PORT_MAX - EPH_FIRST + 1;
    start = eph_cursor;
    if (start < EPH_FIRST || start > PORT_MAX) start = EPH_FIRST;
    for (int i = 0; i < SCAN_WIN; i++) begin
      p = EPH_FIRST + ((start - EPH_FIRST + i) % span);
      if (port_users[p] == 0) begin
        id = sock_total;
        r = rand_req();
        r.op = OP_CREATE;
        send_req(r, 1'b0, '0);
        r = rand_req();
        r.op    = OP_BIND;
        r.sid   = 8'(id);
        r.rport = 16'(p);
        send_req(r, 1'b0, '0);
      end
    end
    id = sock_total;
    r = rand_req();
    r.op = OP_CREATE;
    send_req(r, 1'b0, '0);
    r = rand_req();
    r.op    = OP_BIND;
    r.sid   = 8'(id);
    r.rport = '0;
    send_req(r, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall, compare against the oldest owed result,
  // watchdog on cycles without any beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall    <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 8);
      if (out_valid && !out_stall) begin
        seen      = '0;
        seen.st   = status_t'(status);
        seen.ok   = success;
        seen.sock = new_sock_id;
        seen.core = assigned_core;
        seen.port = bound_port;
        seen.tag  = tag_out;
        if (pending_resp.size() == 0) begin
          bad_resp_count++;
          if (bad_resp_count <= 10)
            $display("unexpected result: st=%0d ok=%0d sock=%0d core=%0d port=%0d tag=%h",
                     seen.st, seen.ok, seen.sock, seen.core, seen.port, seen.tag);
        end else begin
          want_now = pending_resp.pop_front();
          if (seen !== want_now) begin
            bad_resp_count++;
            if (bad_resp_count <= 10) begin
              $display("mismatch: want st=%0d ok=%0d sock=%0d core=%0d port=%0d tag=%h",
                       want_now.st, want_now.ok, want_now.sock, want_now.core,
                       want_now.port, want_now.tag);
              $display("          got  st=%0d ok=%0d sock=%0d core=%0d port=%0d tag=%h",
                       seen.st, seen.ok, seen.sock, seen.core, seen.port, seen.tag);
            end
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  plan_row_t   plan [$];
  logic [31:0] core_set [6] = '{32'd0, 32'd16, 32'hFFFF_FFFF, 32'd3, 32'd1, 32'd7};

  initial begin
    // model state after reset
    sock_total = 0;
    eph_cursor = EPH_FIRST;
    cfg_cores  = CORE_COUNT_RESET;
    cfg_ip     = '0;
    for (int i = 0; i < N_SOCK; i++) begin
      sk_port[i]  = '0;
      sk_share[i] = 1'b0;
      sk_addr[i]  = '0;
    end
    for (int i = 0; i <= PORT_MAX; i++) port_users[i] = '0;

    // directed part, reset configuration (one core)
    //          op         sid    reuse rport       ip            tag
    plan.push_back(row(OP_CREATE, 8'd0,   1'b0, 16'd0,    32'd0,        32'd0,
                       1'b1, ST_OK,      8'd0, 4'd0, 12'd0));
    plan.push_back(row(OP_CREATE, 8'hFF,  1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       1'b1, ST_OK,      8'd1, 4'd0, 12'd0));
    // unknown op, all fields high: no result
    plan.push_back(row(OP_NONE,   8'hFF,  1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       1'b0, ST_OK,      8'd0, 4'd0, 12'd0));
    plan.push_back(row(OP_SETOPT, 8'd0,   1'b1, 16'd0,    32'd0,        32'h0000_0001,
                       1'b1, ST_OK,      8'd0, 4'd0, 12'd0));
    // option other than sharing
    plan.push_back(row(OP_SETOPT, 8'd1,   1'b0, 16'd0,    32'd0,        32'h8000_0000,
                       1'b1, ST_OK,      8'd0, 4'd0, 12'd0));
    // just past and far past the port limit
    plan.push_back(row(OP_BIND,   8'd1,   1'b0, 16'd4096, 32'h1234_5678, 32'h0000_0002,
                       1'b1, ST_RANGE,   8'd0, 4'd0, 12'd0));
    plan.push_back(row(OP_BIND,   8'd1,   1'b1, 16'hFFFF, 32'h1234_5678, 32'h0000_0003,
                       1'b1, ST_RANGE,   8'd0, 4'd0, 12'd0));
    plan.push_back(row(OP_BIND,   8'd0,   1'b0, 16'd4095, 32'd0,        32'h0000_0004,
                       1'b1, ST_OK,      8'd0, 4'd0, 12'd4095));
    // bound sharing socket binds again, asked port ignored
    plan.push_back(row(OP_BIND,   8'd0,   1'b0, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0005,
                       1'b0, ST_OK,      8'd0, 4'd0, 12'd0));
    plan.push_back(row(OP_BIND,   8'd0,   1'b0, 16'd0,    32'd0,        32'h0000_0006,
                       1'b0, ST_OK,      8'd0, 4'd0, 12'd0));
    plan.push_back(row(OP_BIND,   8'd0,   1'b0, 16'd7,    32'd0,        32'h0000_0007,
                       1'b0, ST_OK,      8'd0, 4'd0, 12'd0));
    // fifth sharer on the same port
    plan.push_back(row(OP_BIND,   8'd0,   1'b0, 16'd0,    32'd0,        32'h0000_0008,
                       1'b1, ST_SHARERS, 8'd0, 4'd0, 12'd0));
    // non-sharing socket onto a taken port
    plan.push_back(row(OP_BIND,   8'd1,   1'b0, 16'd4095, 32'd0,        32'h0000_0009,
                       1'b1, ST_IN_USE,  8'd0, 4'd0, 12'd0));
    // ephemeral picks, lowest port, socket never created
    plan.push_back(row(OP_BIND,   8'd1,   1'b0, 16'd0,    32'hA5A5_A5A5, 32'h0000_000A,
                       1'b0, ST_OK,      8'd0, 4'd0, 12'd0));
    plan.push_back(row(OP_BIND,   8'hFF,  1'b0, 16'd1,    32'h5A5A_5A5A, 32'h0000_000B,
                       1'b0, ST_OK,      8'd0, 4'd0, 12'd0));
    plan.push_back(row(OP_CREATE, 8'd0,   1'b0, 16'd0,    32'd0,        32'h0000_000C,
                       1'b0, ST_OK,      8'd0, 4'd0, 12'd0));
    plan.push_back(row(OP_BIND,   8'd2,   1'b0, 16'd0,    32'd0,        32'h0000_000D,
                       1'b0, ST_OK,      8'd0, 4'd0, 12'd0));
    // bound socket without sharing binds again
    plan.push_back(row(OP_BIND,   8'd2,   1'b1, 16'd0,    32'd0,        32'h0000_000E,
                       1'b0, ST_OK,      8'd0, 4'd0, 12'd0));
    plan.push_back(row(OP_SETOPT, 8'hFF,  1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       1'b0, ST_OK,      8'd0, 4'd0, 12'd0));
    plan.push_back(row(OP_BIND,   8'hFF,  1'b0, 16'd1,    32'd0,        32'h0000_000F,
                       1'b0, ST_OK,      8'd0, 4'd0, 12'd0));
    plan.push_back(row(OP_NONE,   8'd0,   1'b0, 16'd0,    32'd0,        32'd0,
                       1'b0, ST_OK,      8'd0, 4'd0, 12'd0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_req(plan[i].req, plan[i].typed, plan[i].want);
    quiesce(SETTLE);

    // random phases, each under its own configuration
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(REG_CORE_COUNT, core_set[ph]);
      if (ph == 0)      cfg_write(REG_LOCAL_IP, 32'hFFFF_FFFF);
      else if (ph == 1) cfg_write(REG_LOCAL_IP, 32'd0);
      else              cfg_write(REG_LOCAL_IP, $urandom);
      calm <= (ph == 3);
      run_random(165);
      if (ph == 1) block_window();
      quiesce(SETTLE);
    end

    // use up the socket table, then keep going past it
    calm <= 1'b0;
    while (sock_total < N_SOCK) begin
      plan[0].req    = rand_req();
      plan[0].req.op = OP_CREATE;
      send_req(plan[0].req, 1'b0, '0);
    end
    run_random(40);

    quiesce(SETTLE);
    if (bad_resp_count == 0 && pending_resp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
